### rtl/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, held off while reset is asserted.
`define HSLRGB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Signal must hold its value in the cycle after the condition.
`define HSLRGB_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

### rtl/hslrgb_pkg.sv
// Package: payload types, widths and pipeline control types of the HSL to RGB converter.
`default_nettype none

package hslrgb_pkg;

	// Fixed field widths of the item payloads
	localparam int unsigned HUE_W = 16;
	localparam int unsigned SL_W  = 17;
	localparam int unsigned CH_W  = 8;

	// Default fraction width of the internal fixed-point math
	localparam int unsigned FRAC_BITS_DEF = 16;

	// Number of register stages in the datapath
	localparam int unsigned NUM_STAGES = 6;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SL_W-1:0]  saturation;
		logic [SL_W-1:0]  lightness;
	} hsl_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// Per-stage load strobes from the flow control to the datapath
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} stage_en_t;

endpackage

`default_nettype wire

### rtl/hsl_to_rgb_pixel.sv
// Top level: HSL to RGB pixel converter with valid/ready flow control.
// Throughput: one item per cycle; each stage stalls only when it holds an item
// and the stage after it is full and stalled, so bubbles close up under backpressure.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
`default_nettype none

module hsl_to_rgb_pixel
	import hslrgb_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic hsl_valid,
	output logic hsl_ready,
	input  hsl_t hsl,
	output logic rgb_valid,
	input  logic rgb_ready,
	output rgb_t rgb
);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES:0]   rdy;
	logic [NUM_STAGES-1:0] vin;
	stage_en_t             en;

	// Per-stage ready: a stage can load when empty or when it drains this cycle
	always_comb begin
		rdy[NUM_STAGES] = rgb_ready;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	// Valid arriving at each stage
	assign vin = {vld_q[NUM_STAGES-2:0], hsl_valid};

	always_comb begin
		for (int k = 0; k < NUM_STAGES; k++) begin
			en.load[k] = rdy[k] && vin[k];
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	assign hsl_ready = rdy[0];
	assign rgb_valid = vld_q[NUM_STAGES-1];

	hslrgb_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk (clk),
		.en  (en),
		.hsl (hsl),
		.rgb (rgb)
	);

endmodule

`default_nettype wire

### rtl/hslrgb_datapath.sv
// Six-stage datapath of the HSL to RGB converter.
`default_nettype none

module hslrgb_datapath
	import hslrgb_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  stage_en_t en,
	input  hsl_t      hsl,
	output rgb_t      rgb
);

	localparam int unsigned W  = FRAC_BITS + 1;
	localparam int unsigned HX = (HUE_W > FRAC_BITS) ? HUE_W : FRAC_BITS;
	localparam int unsigned SX = (SL_W > W) ? SL_W : W;
	localparam int unsigned PW = 2 * W;
	localparam int unsigned MW = W + FRAC_BITS;
	localparam int unsigned BW = W + CH_W;

	localparam logic [W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [W-1:0] HALF = ONE >> 1;

	// Hue sextants, red toward magenta
	localparam logic [2:0] SEXT_R_Y = 3'd0;
	localparam logic [2:0] SEXT_Y_G = 3'd1;
	localparam logic [2:0] SEXT_G_C = 3'd2;
	localparam logic [2:0] SEXT_C_B = 3'd3;
	localparam logic [2:0] SEXT_B_M = 3'd4;

	// floor(x * 255 / ONE), x never above ONE
	function automatic logic [CH_W-1:0] to_byte(input logic [W-1:0] x);
		logic [BW-1:0] scaled;
		scaled = {x, {CH_W{1'b0}}} - {{CH_W{1'b0}}, x};
		return scaled[FRAC_BITS +: CH_W];
	endfunction

	// Stage 1: wrap hue, clamp s and l, l*s product, hue*6
	logic [HX-1:0]        hue_x;
	logic [FRAC_BITS-1:0] hue_f;
	logic [SX-1:0]        sat_x, lit_x;
	logic [W-1:0]         s_c, l_c;
	logic [PW-1:0]        ls_full;
	logic [FRAC_BITS+2:0] h6;

	assign hue_x   = HX'(hsl.hue);
	assign hue_f   = hue_x[FRAC_BITS-1:0];
	assign sat_x   = SX'(hsl.saturation);
	assign lit_x   = SX'(hsl.lightness);
	assign s_c     = (sat_x > SX'(ONE)) ? ONE : sat_x[W-1:0];
	assign l_c     = (lit_x > SX'(ONE)) ? ONE : lit_x[W-1:0];
	assign ls_full = PW'(l_c) * PW'(s_c);
	assign h6      = {2'b00, hue_f, 1'b0} + {1'b0, hue_f, 2'b00};

	logic [W-1:0]         l_s1, s_s1, ls_s1;
	logic                 lhalf_s1;
	logic [2:0]           sext_s1;
	logic [FRAC_BITS-1:0] fract_s1;

	always_ff @(posedge clk) begin
		if (en.load[0]) begin
			l_s1     <= l_c;
			s_s1     <= s_c;
			ls_s1    <= ls_full[FRAC_BITS +: W];
			lhalf_s1 <= (l_c <= HALF);
			sext_s1  <= h6[FRAC_BITS +: 3];
			fract_s1 <= h6[FRAC_BITS-1:0];
		end
	end

	// Stage 2: chroma bound v, clamped to one
	logic [W:0]   v_sum;
	logic [W-1:0] v_c;

	always_comb begin
		if (lhalf_s1) begin
			v_sum = {1'b0, l_s1} + {1'b0, ls_s1};
		end else begin
			v_sum = {1'b0, l_s1} + {1'b0, s_s1} - {1'b0, ls_s1};
		end
		v_c = (v_sum > {1'b0, ONE}) ? ONE : v_sum[W-1:0];
	end

	logic [W-1:0]         v_s2, l_s2;
	logic [2:0]           sext_s2;
	logic [FRAC_BITS-1:0] fract_s2;

	always_ff @(posedge clk) begin
		if (en.load[1]) begin
			v_s2     <= v_c;
			l_s2     <= l_s1;
			sext_s2  <= sext_s1;
			fract_s2 <= fract_s1;
		end
	end

	// Stage 3: minimum m = 2l - v clamped to [0, v], span v - m
	logic [W:0]   twol, m_raw;
	logic [W-1:0] m_c;

	always_comb begin
		twol  = {l_s2, 1'b0};
		m_raw = (twol > {1'b0, v_s2}) ? (twol - {1'b0, v_s2}) : '0;
		m_c   = (m_raw > {1'b0, v_s2}) ? v_s2 : m_raw[W-1:0];
	end

	logic [W-1:0]         v_s3, m_s3, d_s3;
	logic [2:0]           sext_s3;
	logic [FRAC_BITS-1:0] fract_s3;

	always_ff @(posedge clk) begin
		if (en.load[2]) begin
			v_s3     <= v_s2;
			m_s3     <= m_c;
			d_s3     <= v_s2 - m_c;
			sext_s3  <= sext_s2;
			fract_s3 <= fract_s2;
		end
	end

	// Stage 4: vsf = (v - m) * fract, truncated
	logic [MW-1:0] vsf_full;

	assign vsf_full = MW'(d_s3) * MW'(fract_s3);

	logic [W-1:0] v_s4, m_s4, vsf_s4;
	logic [2:0]   sext_s4;

	always_ff @(posedge clk) begin
		if (en.load[3]) begin
			v_s4    <= v_s3;
			m_s4    <= m_s3;
			vsf_s4  <= vsf_full[FRAC_BITS +: W];
			sext_s4 <= sext_s3;
		end
	end

	// Stage 5: rising/falling mids and per-sextant channel select.
	// Zero v only occurs at zero lightness, where every choice is already zero.
	logic [W-1:0] mid1, mid2, r_c, g_c, b_c;

	always_comb begin
		mid1 = m_s4 + vsf_s4;
		mid2 = v_s4 - vsf_s4;
		case (sext_s4)
			SEXT_R_Y: begin
				r_c = v_s4; g_c = mid1; b_c = m_s4;
			end
			SEXT_Y_G: begin
				r_c = mid2; g_c = v_s4; b_c = m_s4;
			end
			SEXT_G_C: begin
				r_c = m_s4; g_c = v_s4; b_c = mid1;
			end
			SEXT_C_B: begin
				r_c = m_s4; g_c = mid2; b_c = v_s4;
			end
			SEXT_B_M: begin
				r_c = mid1; g_c = m_s4; b_c = v_s4;
			end
			default: begin
				r_c = v_s4; g_c = m_s4; b_c = mid2;
			end
		endcase
	end

	logic [W-1:0] r_s5, g_s5, b_s5;

	always_ff @(posedge clk) begin
		if (en.load[4]) begin
			r_s5 <= r_c;
			g_s5 <= g_c;
			b_s5 <= b_c;
		end
	end

	// Stage 6: scale to 8 bits
	rgb_t rgb_s6;

	always_ff @(posedge clk) begin
		if (en.load[5]) begin
			rgb_s6.red   <= to_byte(r_s5);
			rgb_s6.green <= to_byte(g_s5);
			rgb_s6.blue  <= to_byte(b_s5);
		end
	end

	assign rgb = rgb_s6;

endmodule

`default_nettype wire

### rtl/hslrgb_checker.sv
// Port-level checker for the HSL to RGB converter, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module hslrgb_checker
	import hslrgb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic hsl_valid,
	input logic hsl_ready,
	input hsl_t hsl,
	input logic rgb_valid,
	input logic rgb_ready,
	input rgb_t rgb
);

	// Accepted colors with a known answer, and the matching pixel shapes
	logic gray_in, black_in, gray_out, black_out;

	assign gray_in   = hsl_valid && hsl_ready && (hsl.saturation == '0);
	assign black_in  = hsl_valid && hsl_ready && (hsl.lightness == '0);
	assign gray_out  = rgb_valid && (rgb.red == rgb.green) && (rgb.green == rgb.blue);
	assign black_out = rgb_valid && (rgb.red == '0) && (rgb.green == '0) && (rgb.blue == '0);

	// A stalled result stays offered
	`HSLRGB_ASSERT(a_out_valid_hold, clk, arst_n, (rgb_valid && !rgb_ready) |=> rgb_valid, "rgb_valid dropped while stalled")

	// A stalled result keeps its value
	`HSLRGB_ASSERT_HOLD(a_out_data_hold, clk, arst_n, rgb_valid && !rgb_ready, rgb, "rgb changed while stalled")

	// With the sink ready, every stage drains, so the input is ready too
	`HSLRGB_ASSERT(a_ready_chain, clk, arst_n, rgb_ready |-> hsl_ready, "input not ready with output ready")

	// Zero saturation gives gray at the output after accept under free flow
	`HSLRGB_ASSERT(a_gray, clk, arst_n, gray_in ##1 rgb_ready [*5] |=> gray_out, "zero saturation not gray")

	// Zero lightness gives black at the output after accept under free flow
	`HSLRGB_ASSERT(a_black, clk, arst_n, black_in ##1 rgb_ready [*5] |=> black_out, "zero lightness not black")

endmodule

bind hsl_to_rgb_pixel hslrgb_checker u_hslrgb_checker (.*);

`default_nettype wire
